// File: rtl/vsam_pkg.sv
// Shared types, constants and helper functions for the vital sign anomaly monitor.
`timescale 1ns / 1ps

package vsam_pkg;

    localparam int VALUE_W    = 32;
    localparam int LIM_W      = 32;
    localparam int CFG_DATA_W = 2 * LIM_W;
    localparam int CFG_IDX_W  = 3;
    localparam int RULE_W     = 4;

    // compare width covering both a reading and a limit
    localparam int CMP_W = (VALUE_W > LIM_W) ? VALUE_W : LIM_W;
    // |min| + |max| needs one bit over a reading
    localparam int SUM_W = (VALUE_W + 1 > LIM_W) ? VALUE_W + 1 : LIM_W;

    localparam logic [CFG_IDX_W-1:0] REG_TEMP_LIMITS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPO2_LIMITS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYS_LIMITS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIA_LIMITS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ECG_AMP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RULES       = 3'd5;

    localparam int RULE_TEMP = 0;
    localparam int RULE_SPO2 = 1;
    localparam int RULE_SYS  = 2;
    localparam int RULE_DIA  = 3;

    typedef enum logic [1:0] {
        KIND_TEMP = 2'd0,
        KIND_SPO2 = 2'd1,
        KIND_BP   = 2'd2,
        KIND_ECG  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                     kind;
        logic signed [VALUE_W-1:0] value_primary;
        logic signed [VALUE_W-1:0] value_secondary;
        logic                      set_end;
    } t_in_beat;

    typedef struct packed {
        logic                      point_anomaly;
        logic                      ecg_seen;
        logic                      ecg_amplitude_anomaly;
        logic signed [VALUE_W-1:0] ecg_min;
        logic signed [VALUE_W-1:0] ecg_max;
    } t_out_beat;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] temp_limits;
        logic [CFG_DATA_W-1:0] spo2_limits;
        logic [CFG_DATA_W-1:0] systolic_limits;
        logic [CFG_DATA_W-1:0] diastolic_limits;
        logic [LIM_W-1:0]      ecg_amplitude_limit;
        logic [RULE_W-1:0]     rules_present;
    } t_cfg;

    // low limit in the lower half, high limit in the upper half; bounds inclusive
    function automatic logic in_limits(input logic signed [VALUE_W-1:0] v,
                                       input logic [CFG_DATA_W-1:0] lim);
        logic signed [CMP_W-1:0] ve;
        logic signed [CMP_W-1:0] lo;
        logic signed [CMP_W-1:0] hi;
        ve = CMP_W'(v);
        lo = CMP_W'(signed'(lim[LIM_W-1:0]));
        hi = CMP_W'(signed'(lim[CFG_DATA_W-1:LIM_W]));
        return (ve >= lo) && (ve <= hi);
    endfunction

    function automatic logic [VALUE_W-1:0] magnitude(input logic signed [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] u;
        u = v;
        return u[VALUE_W-1] ? (~u + VALUE_W'(1)) : u;
    endfunction

endpackage

// File: rtl/vsam_cfg_regs.sv
// Configuration register file: limits, amplitude bound and rule presence bits.
`timescale 1ns / 1ps

module vsam_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [vsam_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vsam_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output vsam_pkg::t_cfg                  o_cfg
);
    import vsam_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_TEMP_LIMITS: n_cfg.temp_limits      = i_cfg_data;
                REG_SPO2_LIMITS: n_cfg.spo2_limits      = i_cfg_data;
                REG_SYS_LIMITS:  n_cfg.systolic_limits  = i_cfg_data;
                REG_DIA_LIMITS:  n_cfg.diastolic_limits = i_cfg_data;
                REG_ECG_AMP:     n_cfg.ecg_amplitude_limit = i_cfg_data[LIM_W-1:0];
                REG_RULES:       n_cfg.rules_present    = i_cfg_data[RULE_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/vsam_point_check.sv
// Point anomaly check of one reading against the limits of its sensor kind.
`timescale 1ns / 1ps

module vsam_point_check (
    input  vsam_pkg::t_in_beat i_beat,
    input  vsam_pkg::t_cfg     i_cfg,
    output logic               o_point
);
    import vsam_pkg::*;

    logic sys_ok;
    logic dia_ok;

    // a missing pressure rule fails the reading
    assign sys_ok = i_cfg.rules_present[RULE_SYS]
                    && in_limits(i_beat.value_primary, i_cfg.systolic_limits);
    assign dia_ok = i_cfg.rules_present[RULE_DIA]
                    && in_limits(i_beat.value_secondary, i_cfg.diastolic_limits);

    always_comb begin
        unique case (i_beat.kind)
            KIND_TEMP: o_point = i_cfg.rules_present[RULE_TEMP]
                                 && !in_limits(i_beat.value_primary, i_cfg.temp_limits);
            KIND_SPO2: o_point = i_cfg.rules_present[RULE_SPO2]
                                 && !in_limits(i_beat.value_primary, i_cfg.spo2_limits);
            KIND_BP:   o_point = !(sys_ok && dia_ok);
            KIND_ECG:  o_point = 1'b0;
            default:   o_point = 1'b0;
        endcase
    end

endmodule

// File: rtl/vsam_ecg_track.sv
// Running ECG min/max over one patient set and the amplitude check at set end.
`timescale 1ns / 1ps

module vsam_ecg_track (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_step,
    input  vsam_pkg::t_in_beat               i_beat,
    input  logic [vsam_pkg::LIM_W-1:0]       i_amp_limit,
    output logic                             o_seen,
    output logic                             o_amp_anomaly,
    output logic signed [vsam_pkg::VALUE_W-1:0] o_min,
    output logic signed [vsam_pkg::VALUE_W-1:0] o_max
);
    import vsam_pkg::*;

    logic                      r_any;
    logic signed [VALUE_W-1:0] r_lo;
    logic signed [VALUE_W-1:0] r_hi;
    logic                      n_any;
    logic signed [VALUE_W-1:0] n_lo;
    logic signed [VALUE_W-1:0] n_hi;
    logic [SUM_W-1:0]          amp_sum;

    // tracking state after this beat; state stays zero while no ECG was seen
    always_comb begin
        n_any = r_any;
        n_lo  = r_lo;
        n_hi  = r_hi;
        if (i_beat.kind == KIND_ECG) begin
            n_any = 1'b1;
            if (!r_any || (i_beat.value_primary < r_lo)) begin
                n_lo = i_beat.value_primary;
            end
            if (!r_any || (i_beat.value_primary > r_hi)) begin
                n_hi = i_beat.value_primary;
            end
        end
    end

    assign amp_sum = SUM_W'(magnitude(n_lo)) + SUM_W'(magnitude(n_hi));

    assign o_seen        = n_any;
    assign o_amp_anomaly = i_beat.set_end && n_any && (amp_sum > SUM_W'(i_amp_limit));
    assign o_min         = n_lo;
    assign o_max         = n_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any <= 1'b0;
            r_lo  <= '0;
            r_hi  <= '0;
        end else if (i_step) begin
            if (i_beat.set_end) begin
                r_any <= 1'b0;
                r_lo  <= '0;
                r_hi  <= '0;
            end else begin
                r_any <= n_any;
                r_lo  <= n_lo;
                r_hi  <= n_hi;
            end
        end
    end

endmodule

// File: rtl/vital_sign_anomaly_monitor.sv
// Top level of the vital sign anomaly monitor: input register, checks, result register.
`timescale 1ns / 1ps

// Each reading beat gives exactly one result beat. A beat is registered on
// input, checked combinationally (limit compares, ECG min/max update and the
// |min| + |max| amplitude compare) and written to the result register, so the
// block takes one beat per cycle while the result register is not held. A result
// is presented once its beat has passed the input register and then the result
// register. Both sides stall independently: with a result held, one more beat
// can still be taken into the input register. The ECG tracking state updates as
// a beat moves into the result register, which is what lets consecutive ECG
// beats follow each other without gaps. Configuration writes take effect on the
// next cycle and are meant for when the block is idle.
module vital_sign_anomaly_monitor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  vsam_pkg::t_in_beat              i_in_beat,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output vsam_pkg::t_out_beat             o_out_beat,
    input  logic                            i_cfg_we,
    input  logic [vsam_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vsam_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import vsam_pkg::*;

    t_cfg      cfg;
    logic      r_in_valid;
    t_in_beat  r_in;
    logic      r_out_valid;
    t_out_beat r_out;
    t_out_beat n_out;
    logic      advance;
    logic      step;

    vsam_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // result register free or being emptied this cycle
    assign advance    = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    vsam_point_check u_point_check (
        .i_beat (r_in),
        .i_cfg  (cfg),
        .o_point(n_out.point_anomaly)
    );

    vsam_ecg_track u_ecg_track (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_beat       (r_in),
        .i_amp_limit  (cfg.ecg_amplitude_limit),
        .o_seen       (n_out.ecg_seen),
        .o_amp_anomaly(n_out.ecg_amplitude_anomaly),
        .o_min        (n_out.ecg_min),
        .o_max        (n_out.ecg_max)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_beat;
        end
        if (step) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

// File: dv/tb_vital_sign_anomaly_monitor.sv
// Testbench for the vital sign anomaly monitor: scoreboard, stimulus and result checks.
`timescale 1ns / 1ps

module tb_vital_sign_anomaly_monitor;
    import vsam_pkg::*;

    // Tracks register settings and ECG set state, predicts each result beat.
    class vitals_scoreboard;
        logic [CFG_DATA_W-1:0]     limits [4];
        logic [LIM_W-1:0]          amp_limit;
        logic [RULE_W-1:0]         rules;
        logic signed [VALUE_W-1:0] ecg_lo;
        logic signed [VALUE_W-1:0] ecg_hi;
        bit                        ecg_any;
        t_out_beat                 pending_results [$];
        int                        mismatches;
        int                        readings;
        int                        sets_closed;
        int                        point_hits;
        int                        amp_hits;

        function new();
            foreach (limits[i]) limits[i] = '0;
            amp_limit   = '0;
            rules       = '0;
            ecg_lo      = '0;
            ecg_hi      = '0;
            ecg_any     = 1'b0;
            mismatches  = 0;
            readings    = 0;
            sets_closed = 0;
            point_hits  = 0;
            amp_hits    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TEMP_LIMITS: limits[RULE_TEMP] = data;
                REG_SPO2_LIMITS: limits[RULE_SPO2] = data;
                REG_SYS_LIMITS:  limits[RULE_SYS]  = data;
                REG_DIA_LIMITS:  limits[RULE_DIA]  = data;
                REG_ECG_AMP:     amp_limit = data[LIM_W-1:0];
                REG_RULES:       rules = data[RULE_W-1:0];
                default: ;
            endcase
        endfunction

        // inclusive bounds, low half / high half of the register
        function bit in_band(logic signed [VALUE_W-1:0] v, logic [CFG_DATA_W-1:0] lim);
            longint x;
            longint lo;
            longint hi;
            x  = v;
            lo = signed'(lim[LIM_W-1:0]);
            hi = signed'(lim[CFG_DATA_W-1:LIM_W]);
            return (x >= lo) && (x <= hi);
        endfunction

        function longint abs_of(longint x);
            return (x < 0) ? -x : x;
        endfunction

        function void note_reading(t_in_beat b);
            t_out_beat r;
            bit        pt;
            bit        amp;
            pt  = 1'b0;
            amp = 1'b0;
            readings++;
            case (b.kind)
                KIND_TEMP:
                    pt = rules[RULE_TEMP] && !in_band(b.value_primary, limits[RULE_TEMP]);
                KIND_SPO2:
                    pt = rules[RULE_SPO2] && !in_band(b.value_primary, limits[RULE_SPO2]);
                KIND_BP:
                    // a missing pressure rule counts as out of range
                    pt = !((rules[RULE_SYS] && in_band(b.value_primary, limits[RULE_SYS])) &&
                           (rules[RULE_DIA] && in_band(b.value_secondary, limits[RULE_DIA])));
                default: begin
                    if (!ecg_any) begin
                        ecg_lo  = b.value_primary;
                        ecg_hi  = b.value_primary;
                        ecg_any = 1'b1;
                    end else begin
                        if (b.value_primary < ecg_lo) ecg_lo = b.value_primary;
                        if (b.value_primary > ecg_hi) ecg_hi = b.value_primary;
                    end
                end
            endcase
            if (b.set_end && ecg_any)
                amp = (abs_of(longint'(ecg_lo)) + abs_of(longint'(ecg_hi))) > longint'(amp_limit);
            r.point_anomaly         = pt;
            r.ecg_seen              = ecg_any;
            r.ecg_amplitude_anomaly = amp;
            r.ecg_min               = ecg_any ? ecg_lo : '0;
            r.ecg_max               = ecg_any ? ecg_hi : '0;
            pending_results.push_back(r);
            point_hits += pt;
            amp_hits   += amp;
            if (b.set_end) begin
                ecg_lo  = '0;
                ecg_hi  = '0;
                ecg_any = 1'b0;
                sets_closed++;
            end
        endfunction

        function void compare_field(string name, logic [VALUE_W-1:0] want,
                                    logic [VALUE_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_out_beat got);
            t_out_beat want;
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: %p", got);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("point_anomaly", want.point_anomaly, got.point_anomaly);
            compare_field("ecg_seen", want.ecg_seen, got.ecg_seen);
            compare_field("ecg_amplitude_anomaly", want.ecg_amplitude_anomaly,
                          got.ecg_amplitude_anomaly);
            compare_field("ecg_min", want.ecg_min, got.ecg_min);
            compare_field("ecg_max", want.ecg_max, got.ecg_max);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_in_beat              in_beat;
    logic                  out_valid;
    logic                  out_ready;
    t_out_beat             out_beat;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    vitals_scoreboard sb = new();

    int rx_mode      = 0;
    bit hold_request = 1'b0;
    bit tx_gaps      = 1'b0;
    int burst_left   = 0;
    int settings_cnt = 0;

    vital_sign_anomaly_monitor dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) sb.note_reading(in_beat);
        if (rst_n && out_valid && out_ready) sb.check_result(out_beat);
    end

    // receiver: always ready, random, or a rotating pattern it renews itself
    initial begin
        int          hold_left;
        int          pat_age;
        logic [15:0] pat;
        hold_left = 0;
        pat_age   = 0;
        pat       = 16'hA5C3;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = $urandom_range(60, 120);
            end
            if (pat_age == 63) pat = 16'($urandom) | 16'h0101;
            pat_age = (pat_age + 1) % 64;
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 99) < 55);
                    default: begin
                        out_ready <= pat[0];
                        pat = {pat[0], pat[15:1]};
                    end
                endcase
            end
        end
    end

    initial begin
        #5ms;
        $display("tb_vital_sign_anomaly_monitor: errors");
        $finish;
    end

    function automatic logic [31:0] fx(int whole);
        return 32'(whole) << 16;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] band(logic [31:0] lo, logic [31:0] hi);
        return {hi, lo};
    endfunction

    function automatic t_in_beat mk(t_kind k, logic [31:0] p, logic [31:0] s, logic e);
        t_in_beat b;
        b.kind            = k;
        b.value_primary   = p;
        b.value_secondary = s;
        b.set_end         = e;
        return b;
    endfunction

    // mostly near a limit edge or in a plausible range, sometimes anything
    function automatic logic [31:0] pick_value(logic [CFG_DATA_W-1:0] lim);
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return lim[31:0] + $urandom_range(0, 4) - 2;
            2: return lim[63:32] + $urandom_range(0, 4) - 2;
            default: return fx(30) + $urandom_range(0, 32'h0078_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_ecg();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return (sb.amp_limit >> 1) + $urandom_range(0, 8) - 4;
            2: return -(sb.amp_limit >> 1) + $urandom_range(0, 8) - 4;
            default: return $urandom_range(0, 32'h0006_0000) - 32'h0003_0000;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_band();
        logic signed [31:0] a;
        logic signed [31:0] b;
        a = $urandom;
        b = $urandom;
        if ($urandom_range(0, 3) != 0 && a > b) return band(b, a);
        return band(a, b);
    endfunction

    task automatic send_reading(input t_in_beat b);
        if (tx_gaps && burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (burst_left > 0) burst_left--;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic load_settings(input logic [CFG_DATA_W-1:0] t_lim, s_lim, sys_lim, dia_lim,
                                 input logic [LIM_W-1:0] amp, input logic [RULE_W-1:0] rl);
        put_reg(REG_TEMP_LIMITS, t_lim);
        put_reg(REG_SPO2_LIMITS, s_lim);
        put_reg(REG_SYS_LIMITS, sys_lim);
        put_reg(REG_DIA_LIMITS, dia_lim);
        put_reg(REG_ECG_AMP, CFG_DATA_W'(amp));
        put_reg(REG_RULES, CFG_DATA_W'(rl));
        cfg_we <= 1'b0;
        settings_cnt++;
    endtask

    task automatic random_reading();
        t_kind       k;
        logic [31:0] p;
        logic [31:0] s;
        k = t_kind'($urandom_range(0, 3));
        s = $urandom;
        case (k)
            KIND_TEMP: p = pick_value(sb.limits[RULE_TEMP]);
            KIND_SPO2: p = pick_value(sb.limits[RULE_SPO2]);
            KIND_BP: begin
                p = pick_value(sb.limits[RULE_SYS]);
                s = pick_value(sb.limits[RULE_DIA]);
            end
            default: p = pick_ecg();
        endcase
        send_reading(mk(k, p, s, $urandom_range(0, 7) == 0));
    endtask

    initial begin
        logic [31:0] j;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_beat   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: no rules, zero amplitude limit
        send_reading(mk(KIND_TEMP, 32'h7FFF_FFFF, 32'h0, 1'b0));
        send_reading(mk(KIND_BP, 32'h0, 32'h0, 1'b0));
        send_reading(mk(KIND_ECG, 32'h0, 32'hFFFF_FFFF, 1'b1));
        settle();

        load_settings(band(fx(36), fx(38)), band(fx(90), fx(100)),
                      band(fx(90), fx(140)), band(fx(60), fx(90)), fx(2), 4'hF);
        send_reading(mk(KIND_TEMP, fx(36), 32'h0, 1'b0));
        send_reading(mk(KIND_TEMP, fx(36) - 1, 32'h0, 1'b0));
        send_reading(mk(KIND_TEMP, fx(38), 32'h0, 1'b0));
        send_reading(mk(KIND_TEMP, fx(38) + 1, 32'h8000_0000, 1'b0));
        send_reading(mk(KIND_SPO2, fx(95), 32'hFFFF_FFFF, 1'b0));
        send_reading(mk(KIND_SPO2, fx(89), 32'h0, 1'b0));
        send_reading(mk(KIND_BP, fx(120), fx(80), 1'b0));
        send_reading(mk(KIND_BP, fx(150), fx(80), 1'b0));
        send_reading(mk(KIND_BP, fx(120), fx(95), 1'b0));
        send_reading(mk(KIND_ECG, fx(1), 32'h0, 1'b0));
        // |min| + |max| lands exactly on the limit
        send_reading(mk(KIND_ECG, fx(-1), 32'h0, 1'b1));
        send_reading(mk(KIND_TEMP, fx(37), 32'h0, 1'b1));
        send_reading(mk(KIND_ECG, 32'h7FFF_FFFF, 32'h0, 1'b0));
        send_reading(mk(KIND_ECG, 32'h8000_0000, 32'h0, 1'b0));
        send_reading(mk(KIND_SPO2, fx(95), 32'h0, 1'b1));
        settle();

        // inverted temperature band, systolic rule missing, widest amplitude limit
        load_settings(band(fx(38), fx(36)), band(fx(90), fx(100)),
                      band(fx(90), fx(140)), band(fx(60), fx(90)), 32'hFFFF_FFFF, 4'b1011);
        send_reading(mk(KIND_TEMP, fx(37), 32'h0, 1'b0));
        send_reading(mk(KIND_SPO2, fx(95), 32'h0, 1'b0));
        send_reading(mk(KIND_BP, fx(120), fx(80), 1'b0));
        send_reading(mk(KIND_ECG, 32'h8000_0000, 32'h0, 1'b1));
        send_reading(mk(KIND_ECG, 32'h8000_0000, 32'h0, 1'b0));
        send_reading(mk(KIND_ECG, 32'h7FFF_FFFF, 32'h0, 1'b1));
        settle();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin
                    j = $urandom_range(0, 32'hFFFF);
                    load_settings(band(fx(36) + j, fx(38) - j), band(fx(90), fx(100) - j),
                                  band(fx(90) + j, fx(140)), band(fx(60), fx(90) + j),
                                  fx(3) + j, 4'hF);
                end
                1: load_settings(band(32'h8000_0000, 32'h7FFF_FFFF),
                                 band(32'h8000_0000, 32'h7FFF_FFFF),
                                 band(32'h8000_0000, 32'h7FFF_FFFF),
                                 band(32'h8000_0000, 32'h7FFF_FFFF), 32'h0, 4'hF);
                2: load_settings('0, '0, '0, '0, 32'hFFFF_FFFF, 4'h0);
                default: load_settings(random_band(), random_band(), random_band(),
                                       random_band(), $urandom, RULE_W'($urandom));
            endcase
            rx_mode    = ph % 3;
            tx_gaps    = (ph % 2) == 1;
            burst_left = 0;
            // long receiver hold-off while readings keep coming
            if (ph == 1 || ph == 4) hold_request = 1'b1;
            repeat (116) random_reading();
            settle();
        end

        $display("covered %0d readings in %0d closed patient sets over %0d register settings",
                 sb.readings, sb.sets_closed, settings_cnt);
        $display("flagged %0d point anomalies and %0d ECG amplitude anomalies",
                 sb.point_hits, sb.amp_hits);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("tb_vital_sign_anomaly_monitor: clean");
        end else begin
            $display("tb_vital_sign_anomaly_monitor: errors");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/vsam_pkg.sv
rtl/vsam_cfg_regs.sv
rtl/vsam_point_check.sv
rtl/vsam_ecg_track.sv
rtl/vital_sign_anomaly_monitor.sv
dv/tb_vital_sign_anomaly_monitor.sv
